// ----- rtl/core/rau_pkg.sv -----
// rational arithmetic unit: shared types and constants
// used by rau_engine and rational_arithmetic_unit; no dependencies
`timescale 1ns / 1ps

package rau_pkg;

    localparam int RAU_WIDTH = 32;
    localparam int RAU_IO_W  = 32;

    typedef enum logic [2:0] {
        REQ_ADD    = 3'd0,
        REQ_SUB    = 3'd1,
        REQ_MUL    = 3'd2,
        REQ_DIV    = 3'd3,
        REQ_REDUCE = 3'd4,
        REQ_GCD    = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_ZERO_DEN = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ENG_MUL = 2'd0,
        ENG_DIV = 2'd1,
        ENG_GCD = 2'd2
    } t_eng_op;

    typedef struct packed {
        logic    start;
        t_eng_op op;
    } t_eng_ctl;

endpackage

// ----- rtl/core/rau_engine.sv -----
// shared iterative unit: shift-add multiply, restoring divide, binary gcd
// one add/subtract/compare per cycle; depends on rau_pkg
`timescale 1ns / 1ps

module rau_engine import rau_pkg::*; #(
    parameter int WIDTH = RAU_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_eng_ctl         i_ctl,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    output logic             o_done,
    output logic [WIDTH-1:0] o_result
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam int K_W   = $clog2(WIDTH + 1);

    typedef enum logic [3:0] {
        E_IDLE = 4'b0001,
        E_MUL  = 4'b0010,
        E_DIV  = 4'b0100,
        E_GCD  = 4'b1000
    } t_eng_state;

    t_eng_state       r_state, n_state;
    logic [WIDTH-1:0] r_x, n_x;
    logic [WIDTH-1:0] r_y, n_y;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [K_W-1:0]   r_k, n_k;
    logic             r_done, n_done;
    logic [WIDTH-1:0] r_res, n_res;

    logic [WIDTH-1:0] rem_sh;
    logic             rem_ge;

    assign rem_sh = {r_acc[WIDTH-2:0], r_x[WIDTH-1]};
    assign rem_ge = (rem_sh >= r_y);

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_done  = 1'b0;
        n_res   = r_res;
        case (r_state)
            E_IDLE: begin
                if (i_ctl.start) begin
                    n_x   = i_x;
                    n_y   = i_y;
                    n_acc = '0;
                    n_cnt = CNT_W'(WIDTH - 1);
                    n_k   = '0;
                    case (i_ctl.op)
                        ENG_MUL: n_state = E_MUL;
                        ENG_DIV: n_state = E_DIV;
                        default: n_state = E_GCD;
                    endcase
                end
            end
            E_MUL: begin
                if (r_y[0]) begin
                    n_acc = r_acc + r_x;
                end
                n_x = r_x << 1;
                n_y = r_y >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_res   = n_acc;
                    n_done  = 1'b1;
                    n_state = E_IDLE;
                end
            end
            E_DIV: begin
                // restoring step: quotient bits shift into x, remainder in acc
                n_acc = rem_ge ? (rem_sh - r_y) : rem_sh;
                n_x   = {r_x[WIDTH-2:0], rem_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_res   = n_x;
                    n_done  = 1'b1;
                    n_state = E_IDLE;
                end
            end
            E_GCD: begin
                if (r_y == '0) begin
                    n_res   = r_x << r_k;
                    n_done  = 1'b1;
                    n_state = E_IDLE;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (r_x > r_y) begin
                    n_x = r_x - r_y;
                end else begin
                    n_y = r_y - r_x;
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_k   <= n_k;
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ----- rtl/core/rational_arithmetic_unit.sv -----
// top level: request sequencer around the shared rau_engine
// depends on rau_pkg and rau_engine
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; busy then stays high
// until the result is out. The result is shown for exactly one cycle with
// o_valid high and cannot be held off by the receiver. Multiply, divide and gcd
// work runs through one shared unit that retires one bit or one gcd step per
// cycle. Add and subtract use three multiply passes, multiply and divide two,
// reduce one gcd and two divides, gcd one gcd pass. Invalid operands or unused
// codes skip the engine and go from S_IDLE straight to S_FIN.
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int WIDTH = RAU_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 i_req_type,
    input  logic signed [RAU_IO_W-1:0] i_a_num,
    input  logic signed [RAU_IO_W-1:0] i_a_den,
    input  logic signed [RAU_IO_W-1:0] i_b_num,
    input  logic signed [RAU_IO_W-1:0] i_b_den,
    output logic                       o_valid,
    output logic signed [RAU_IO_W-1:0] o_res_num,
    output logic signed [RAU_IO_W-1:0] o_res_den,
    output logic [1:0]                 o_status
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_step, n_step;
    logic [1:0]       r_last, n_last;
    logic             r_inval, n_inval;
    logic [2:0]       r_req;
    logic [WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic [WIDTH-1:0] r_t0, r_t1, r_t2;
    logic             r_valid;

    logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
    logic             accept;
    logic             a_pos;

    t_eng_ctl         eng_ctl;
    logic [WIDTH-1:0] eng_x, eng_y;
    logic             eng_done;
    logic [WIDTH-1:0] eng_res;

    logic [WIDTH-1:0] fin_num, fin_den;
    t_status          fin_st;

    assign in_an  = WIDTH'(i_a_num);
    assign in_ad  = WIDTH'(i_a_den);
    assign in_bn  = WIDTH'(i_b_num);
    assign in_bd  = WIDTH'(i_b_den);
    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign a_pos  = !in_an[WIDTH-1] && (in_an != '0) && !in_ad[WIDTH-1] && (in_ad != '0);

    // number of engine passes and operand check per request
    always_comb begin
        n_inval = 1'b0;
        n_last  = 2'd2;
        case (i_req_type)
            REQ_ADD, REQ_SUB: n_last = 2'd2;
            REQ_MUL, REQ_DIV: n_last = 2'd1;
            REQ_REDUCE: begin
                n_last  = 2'd2;
                n_inval = !a_pos;
            end
            REQ_GCD: begin
                n_last  = 2'd0;
                n_inval = !a_pos;
            end
            default: n_inval = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_step  = 2'd0;
                    n_state = n_inval ? S_FIN : S_ISSUE;
                end
            end
            S_ISSUE: n_state = S_WAIT;
            S_WAIT: begin
                if (eng_done) begin
                    n_step = r_step + 1'b1;
                    n_state = (r_step == r_last) ? S_FIN : S_ISSUE;
                end
            end
            S_FIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // operand selection for the current pass
    always_comb begin
        eng_ctl.start = (r_state == S_ISSUE);
        eng_ctl.op    = ENG_MUL;
        eng_x         = r_ad;
        eng_y         = r_bd;
        case (r_req)
            REQ_MUL: begin
                if (r_step == 2'd0) begin
                    eng_x = r_an;
                    eng_y = r_bn;
                end
            end
            REQ_REDUCE, REQ_GCD: begin
                eng_ctl.op = (r_step == 2'd0) ? ENG_GCD : ENG_DIV;
                eng_x      = (r_step == 2'd2) ? r_ad : r_an;
                eng_y      = (r_step == 2'd0) ? r_ad : r_t0;
            end
            default: begin
                // cross products: a_num*b_den, a_den*b_num, a_den*b_den
                case (r_step)
                    2'd0: begin
                        eng_x = r_an;
                        eng_y = r_bd;
                    end
                    2'd1: begin
                        eng_x = r_ad;
                        eng_y = r_bn;
                    end
                    default: begin
                        eng_x = r_ad;
                        eng_y = r_bd;
                    end
                endcase
            end
        endcase
    end

    rau_engine #(
        .WIDTH(WIDTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (eng_ctl),
        .i_x      (eng_x),
        .i_y      (eng_y),
        .o_done   (eng_done),
        .o_result (eng_res)
    );

    always_comb begin
        fin_num = r_an;
        fin_den = r_ad;
        fin_st  = ST_OK;
        if (r_inval) begin
            fin_st = ST_INVALID;
        end else begin
            case (r_req)
                REQ_ADD: begin
                    fin_num = r_t0 + r_t1;
                    fin_den = r_t2;
                end
                REQ_SUB: begin
                    fin_num = r_t0 - r_t1;
                    fin_den = r_t2;
                end
                REQ_MUL, REQ_DIV: begin
                    fin_num = r_t0;
                    fin_den = r_t1;
                end
                REQ_REDUCE: begin
                    fin_num = r_t1;
                    fin_den = r_t2;
                end
                REQ_GCD: begin
                    fin_num = r_t0;
                    fin_den = '0;
                end
                default: fin_st = ST_INVALID;
            endcase
            if ((r_req == REQ_ADD || r_req == REQ_SUB || r_req == REQ_MUL ||
                 r_req == REQ_DIV) && fin_den == '0) begin
                fin_st = ST_ZERO_DEN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_valid <= (r_state == S_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_req_type;
            r_an    <= in_an;
            r_ad    <= in_ad;
            r_bn    <= in_bn;
            r_bd    <= in_bd;
            r_last  <= n_last;
            r_inval <= n_inval;
        end
        if (r_state == S_WAIT && eng_done) begin
            case (r_step)
                2'd0:    r_t0 <= eng_res;
                2'd1:    r_t1 <= eng_res;
                default: r_t2 <= eng_res;
            endcase
        end
        if (r_state == S_FIN) begin
            o_res_num <= RAU_IO_W'($signed(fin_num));
            o_res_den <= RAU_IO_W'($signed(fin_den));
            o_status  <= fin_st;
        end
    end

    assign o_valid = r_valid;

endmodule

// ----- sim/rational_arithmetic_unit_test.sv -----
// self-checking bench for rational_arithmetic_unit: fraction predictor and
// scoreboard class plus directed and random request streams
// depends on rau_pkg and the rational_arithmetic_unit rtl
`timescale 1ns / 1ps

class fraction_board;
    typedef logic signed [rau_pkg::RAU_IO_W-1:0]  io_word_t;
    typedef logic signed [rau_pkg::RAU_WIDTH-1:0] calc_word_t;
    typedef logic [rau_pkg::RAU_WIDTH-1:0]        calc_uword_t;

    typedef struct {
        io_word_t          num;
        io_word_t          den;
        rau_pkg::t_status  status;
    } fraction_t;

    fraction_t expected_fractions[$];
    int        errors;
    int        checked;
    int        n_invalid;
    int        n_zero_den;

    function new();
        errors     = 0;
        checked    = 0;
        n_invalid  = 0;
        n_zero_den = 0;
    endfunction

    // work out the fraction a request must produce and queue it
    function void note_request(logic [2:0] op, io_word_t an_in, io_word_t ad_in,
                               io_word_t bn_in, io_word_t bd_in);
        calc_word_t       an, ad, bn, bd, rn, rd;
        calc_uword_t      p, q, r;
        rau_pkg::t_status st;
        fraction_t        f;
        an = calc_word_t'(an_in);
        ad = calc_word_t'(ad_in);
        bn = calc_word_t'(bn_in);
        bd = calc_word_t'(bd_in);
        rn = an;
        rd = ad;
        st = rau_pkg::ST_OK;
        case (op)
            rau_pkg::REQ_ADD: begin
                rn = an * bd + ad * bn;
                rd = ad * bd;
            end
            rau_pkg::REQ_SUB: begin
                rn = an * bd - ad * bn;
                rd = ad * bd;
            end
            rau_pkg::REQ_MUL: begin
                rn = an * bn;
                rd = ad * bd;
            end
            rau_pkg::REQ_DIV: begin
                rn = an * bd;
                rd = ad * bn;
            end
            rau_pkg::REQ_REDUCE, rau_pkg::REQ_GCD: begin
                if (an <= 0 || ad <= 0) begin
                    st = rau_pkg::ST_INVALID;
                end else begin
                    p = an;
                    q = ad;
                    while (q != 0) begin
                        r = p % q;
                        p = q;
                        q = r;
                    end
                    if (op == rau_pkg::REQ_REDUCE) begin
                        rn = an / calc_word_t'(p);
                        rd = ad / calc_word_t'(p);
                    end else begin
                        rn = p;
                        rd = '0;
                    end
                end
            end
            default: st = rau_pkg::ST_INVALID;
        endcase
        if (op <= rau_pkg::REQ_DIV && rd == 0)
            st = rau_pkg::ST_ZERO_DEN;
        f.num    = io_word_t'(rn);
        f.den    = io_word_t'(rd);
        f.status = st;
        expected_fractions.push_back(f);
    endfunction

    function void check_result(io_word_t num, io_word_t den, logic [1:0] status);
        fraction_t f;
        if (expected_fractions.size() == 0) begin
            $error("result with no request outstanding: num %0d den %0d status %0d",
                   num, den, status);
            errors++;
            return;
        end
        f = expected_fractions.pop_front();
        checked++;
        if (f.status == rau_pkg::ST_INVALID)
            n_invalid++;
        if (f.status == rau_pkg::ST_ZERO_DEN)
            n_zero_den++;
        if (num !== f.num) begin
            $error("res_num mismatch: expected %0d, got %0d", f.num, num);
            errors++;
        end
        if (den !== f.den) begin
            $error("res_den mismatch: expected %0d, got %0d", f.den, den);
            errors++;
        end
        if (status !== f.status) begin
            $error("status mismatch: expected %0d, got %0d", f.status, status);
            errors++;
        end
    endfunction

    function int outstanding();
        return expected_fractions.size();
    endfunction
endclass

module rational_arithmetic_unit_test;
    import rau_pkg::*;

    typedef logic signed [RAU_IO_W-1:0] word_t;

    // op codes the block does not define; they must pass through as invalid
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam int    RANDOM_REQUESTS = 450;
    localparam int    WATCHDOG_LIMIT  = 4000;
    localparam int    TAIL_CYCLES     = 200;
    localparam word_t WORD_MAX        = {1'b0, {(RAU_IO_W-1){1'b1}}};
    localparam word_t WORD_MIN        = {1'b1, {(RAU_IO_W-1){1'b0}}};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_req_type;
    word_t       i_a_num, i_a_den, i_b_num, i_b_den;
    logic        o_valid;
    word_t       o_res_num, o_res_den;
    logic [1:0]  o_status;

    fraction_board board = new();
    int          idle_cycles = 0;
    int          issued = 0;
    int          burst_left = 0;

    rational_arithmetic_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req_type (i_req_type),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .o_valid    (o_valid),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_status   (o_status)
    );

    always #6 i_clk = ~i_clk;

    // sample both sides at the edge and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            board.note_request(i_req_type, i_a_num, i_a_den, i_b_num, i_b_den);
            issued++;
            idle_cycles = 0;
        end else if (i_rst_n && o_valid) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (i_rst_n && o_valid)
            board.check_result(o_res_num, o_res_den, o_status);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a handshake", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // requests go out in bursts; between bursts start may drop for a random gap
    task automatic issue_request(input logic [2:0] op, input word_t an, input word_t ad,
                                 input word_t bn, input word_t bd);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 220)
                                              : $urandom_range(0, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_req_type <= op;
        i_a_num    <= an;
        i_a_den    <= ad;
        i_b_num    <= bn;
        i_b_den    <= bd;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic word_t random_term();
        case ($urandom_range(0, 9))
            0: random_term = '0;
            1: begin
                case ($urandom_range(0, 3))
                    0: random_term = WORD_MAX;
                    1: random_term = WORD_MIN;
                    2: random_term = -1;
                    default: random_term = 1;
                endcase
            end
            2, 3, 4: random_term = word_t'($urandom());
            default: random_term = word_t'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    initial begin
        logic [2:0] op;
        word_t      an, ad, bn, bd;
        int         k, g;

        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_req_type <= REQ_ADD;
        i_a_num    <= '0;
        i_a_den    <= '0;
        i_b_num    <= '0;
        i_b_den    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each op, wrap at the extremes, zero denominators,
        // nonpositive terms for reduce and gcd, spare codes
        issue_request(REQ_ADD, 1, 2, 1, 3);
        issue_request(REQ_SUB, 1, 2, 1, 3);
        issue_request(REQ_MUL, -3, 4, 5, 7);
        issue_request(REQ_DIV, 3, 4, -5, 7);
        issue_request(REQ_ADD, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN);
        issue_request(REQ_MUL, WORD_MIN, WORD_MAX, -1, WORD_MIN);
        issue_request(REQ_SUB, WORD_MIN, -1, WORD_MAX, 1);
        issue_request(REQ_ADD, 1, 0, 1, 5);
        issue_request(REQ_DIV, 1, 5, 0, 7);
        issue_request(REQ_MUL, 7, 65536, 9, 65536);
        issue_request(REQ_REDUCE, 6, 4, 0, 0);
        issue_request(REQ_REDUCE, 0, 4, 1, 1);
        issue_request(REQ_REDUCE, 6, -4, 1, 1);
        issue_request(REQ_REDUCE, WORD_MIN, 4, 1, 1);
        issue_request(REQ_REDUCE, WORD_MAX, WORD_MAX, -1, -1);
        issue_request(REQ_REDUCE, WORD_MAX, 2, 0, 0);
        issue_request(REQ_GCD, 12, 18, WORD_MIN, WORD_MAX);
        issue_request(REQ_GCD, 12, 0, 0, 0);
        issue_request(REQ_GCD, -12, 18, 0, 0);
        issue_request(REQ_GCD, 1, WORD_MAX, 0, 0);
        issue_request(REQ_GCD, 1073741824, 536870912, 0, 0);
        issue_request(REQ_SPARE_6, 5, 9, 2, 3);
        issue_request(REQ_SPARE_7, WORD_MIN, 0, WORD_MAX, -1);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            k = $urandom_range(0, 19);
            if (k < 18)
                op = 3'(k / 3);
            else
                op = (k == 18) ? REQ_SPARE_6 : REQ_SPARE_7;
            an = random_term();
            ad = random_term();
            bn = random_term();
            bd = random_term();
            // mostly well-formed positive terms sharing a factor for reduce/gcd
            if ((op == REQ_REDUCE || op == REQ_GCD) && $urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 5) == 0) begin
                    an = word_t'($urandom() >> 1) | 1;
                    ad = word_t'($urandom() >> 1) | 1;
                end else begin
                    g  = $urandom_range(1, 5000);
                    an = word_t'(g * $urandom_range(1, 20000));
                    ad = word_t'(g * $urandom_range(1, 20000));
                end
            end
            issue_request(op, an, ad, bn, bd);
        end
        start <= 1'b0;

        while (board.outstanding() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests over all eight op codes, %0d results checked",
                 issued, board.checked);
        $display("%0d invalid-operand and %0d zero-denominator results among them",
                 board.n_invalid, board.n_zero_den);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
